// File: design/md4_pkg.sv
package md4_pkg;

  localparam logic [31:0] IvA = 32'h6745_2301;
  localparam logic [31:0] IvB = 32'hEFCD_AB89;
  localparam logic [31:0] IvC = 32'h98BA_DCFE;
  localparam logic [31:0] IvD = 32'h1032_5476;
  localparam logic [31:0] KRound2 = 32'h5A82_7999;
  localparam logic [31:0] KRound3 = 32'h6ED9_EBA1;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenPos = 6'h38;
  localparam logic [5:0]  LastStep = 6'd47;
  localparam logic [5:0]  LastPos = 6'h3F;
  localparam logic [3:0]  LenWordLo = 4'd14;
  localparam logic [3:0]  LenWordHi = 4'd15;
  localparam logic [63:0] BitsPerByte = 64'd8;

  localparam logic [1:0] RoundF = 2'd0;
  localparam logic [1:0] RoundG = 2'd1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LOAD  = 6'b000100,
    S_ROUND = 6'b001000,
    S_FOLD  = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  // Message word used by a step: linear, then column order, then bit-reversed.
  function automatic logic [3:0] word_sel(input logic [5:0] step);
    logic [3:0] idx;
    idx = step[3:0];
    unique case (step[5:4])
      RoundF:  word_sel = idx;
      RoundG:  word_sel = {idx[1:0], idx[3:2]};
      default: word_sel = {idx[0], idx[1], idx[2], idx[3]};
    endcase
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] step);
    logic [3:0] code;
    code = {step[5:4], step[1:0]};
    unique case (code)
      4'd0, 4'd4, 4'd8: rot_amount = 5'd3;
      4'd1:             rot_amount = 5'd7;
      4'd2, 4'd10:      rot_amount = 5'd11;
      4'd3:             rot_amount = 5'd19;
      4'd5:             rot_amount = 5'd5;
      4'd6, 4'd9:       rot_amount = 5'd9;
      4'd7:             rot_amount = 5'd13;
      4'd11:            rot_amount = 5'd15;
      default:          rot_amount = 5'd3;
    endcase
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] tmp;
    tmp = {32'd0, v} << s;
    rotl32 = tmp[63:32] | tmp[31:0];
  endfunction

endpackage

// File: design/md4_message_digest_top.sv
// Takes one message byte per cycle while idle; the 64th byte of a block starts a
// compression (one word-fetch state, 48 steps, one chaining add).
// End of message: padding writes, one or two compressions, then four digest word
// transfers; compressions use the shared step adder and the 16x32 block store.
// Reset (asynchronous, active low) restores the initial chaining words and a zero
// bit count; the block store is not cleared.
module md4_message_digest_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] message_byte
  input  logic        s_axis_tuser_i,   // [0] byte_valid
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [1:0]  m_axis_tuser_o,   // [1:0] word_number
  output logic        m_axis_tlast_o
);
  import md4_pkg::*;

  state_e      state_q, state_d;
  logic [5:0]  step_q, step_d;
  logic [3:0]  widx_q, widx_d;
  logic        first_q, first_d;
  logic        len_q, len_d;
  logic        fin_q, fin_d;
  logic        pend_q, pend_d;
  logic        ovf_q, ovf_d;
  logic [1:0]  oidx_q, oidx_d;
  logic [63:0] cnt_q, cnt_d;
  logic [31:0] chain_q [4];
  logic [31:0] chain_d [4];
  logic [31:0] wacc_q, wacc_d;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] a_d, b_d, c_d, d_d;
  logic [31:0] rdata_q;
  logic [31:0] mem [16];

  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata;
  logic [5:0]  pos, pad_at;
  logic        in_xfer, out_xfer;
  logic [31:0] f_val, sum, step_res, pad_word;

  assign pos      = cnt_q[8:3];
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tdata_o  = chain_q[oidx_q];
  assign m_axis_tuser_o  = oidx_q;
  assign m_axis_tlast_o  = (oidx_q == 2'd3);

  // Shared step unit: a + f(b, c, d) + K + X[k], rotated.
  always_comb begin
    unique case (step_q[5:4])
      RoundF:  f_val = (b_q & c_q) | (~b_q & d_q);
      RoundG:  f_val = ((b_q & c_q) | (b_q & d_q) | (c_q & d_q)) + KRound2;
      default: f_val = (b_q ^ c_q ^ d_q) + KRound3;
    endcase
    sum      = a_q + f_val + rdata_q;
    step_res = rotl32(sum, rot_amount(step_q));
  end

  // Word holding the end mark: bytes already gathered, then 0x80, then zeros.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (2'(k) < pos[1:0]) begin
        pad_word[8*k +: 8] = wacc_q[8*k +: 8];
      end else if (2'(k) == pos[1:0]) begin
        pad_word[8*k +: 8] = PadByte;
      end else begin
        pad_word[8*k +: 8] = 8'd0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    widx_d  = widx_q;
    first_d = first_q;
    len_d   = len_q;
    fin_d   = fin_q;
    pend_d  = pend_q;
    ovf_d   = ovf_q;
    oidx_d  = oidx_q;
    cnt_d   = cnt_q;
    wacc_d  = wacc_q;
    for (int k = 0; k < 4; k++) begin
      chain_d[k] = chain_q[k];
    end
    a_d    = a_q;
    b_d    = b_q;
    c_d    = c_q;
    d_d    = d_q;
    we     = 1'b0;
    waddr  = widx_q;
    wdata  = 32'd0;
    raddr  = word_sel(step_q + 6'd1);
    pad_at = pos;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser_i) begin
            wacc_d[8*pos[1:0] +: 8] = s_axis_tdata_i;
            cnt_d = cnt_q + BitsPerByte;
            pad_at = pos + 6'd1;
            if (pos[1:0] == 2'd3) begin
              we    = 1'b1;
              waddr = pos[5:2];
              wdata = {s_axis_tdata_i, wacc_q[23:0]};
            end
          end
          if (s_axis_tuser_i && pos == LastPos) begin
            state_d = S_LOAD;
            pend_d  = s_axis_tlast_i;
            fin_d   = 1'b0;
            ovf_d   = 1'b0;
          end else if (s_axis_tlast_i) begin
            state_d = S_PAD;
            widx_d  = pad_at[5:2];
            first_d = 1'b1;
            len_d   = (pad_at < LenPos);
            fin_d   = 1'b0;
            ovf_d   = 1'b0;
            pend_d  = 1'b0;
          end
        end
      end
      S_PAD: begin
        we = 1'b1;
        if (first_q) begin
          wdata = pad_word;
        end else if (len_q && widx_q == LenWordLo) begin
          wdata = cnt_q[31:0];
        end else if (len_q && widx_q == LenWordHi) begin
          wdata = cnt_q[63:32];
        end
        first_d = 1'b0;
        if (widx_q == LenWordHi) begin
          state_d = S_LOAD;
          fin_d   = len_q;
          ovf_d   = !len_q;
        end else begin
          widx_d = widx_q + 4'd1;
        end
      end
      S_LOAD: begin
        raddr   = word_sel(6'd0);
        step_d  = 6'd0;
        a_d     = chain_q[0];
        b_d     = chain_q[1];
        c_d     = chain_q[2];
        d_d     = chain_q[3];
        state_d = S_ROUND;
      end
      S_ROUND: begin
        // Registers rotate so that the word being updated always sits in a.
        a_d    = d_q;
        b_d    = step_res;
        c_d    = b_q;
        d_d    = c_q;
        step_d = step_q + 6'd1;
        if (step_q == LastStep) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        if (fin_q) begin
          state_d = S_OUT;
          oidx_d  = 2'd0;
        end else if (pend_q) begin
          pend_d  = 1'b0;
          state_d = S_PAD;
          widx_d  = pos[5:2];
          first_d = 1'b1;
          len_d   = 1'b1;
        end else if (ovf_q) begin
          // The length did not fit: a further block of zeros and the length.
          ovf_d   = 1'b0;
          state_d = S_PAD;
          widx_d  = 4'd0;
          first_d = 1'b0;
          len_d   = 1'b1;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_xfer) begin
          oidx_d = oidx_q + 2'd1;
          if (oidx_q == 2'd3) begin
            state_d    = S_IDLE;
            cnt_d      = 64'd0;
            chain_d[0] = IvA;
            chain_d[1] = IvB;
            chain_d[2] = IvC;
            chain_d[3] = IvD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      step_q     <= 6'd0;
      widx_q     <= 4'd0;
      first_q    <= 1'b0;
      len_q      <= 1'b0;
      fin_q      <= 1'b0;
      pend_q     <= 1'b0;
      ovf_q      <= 1'b0;
      oidx_q     <= 2'd0;
      cnt_q      <= 64'd0;
      chain_q[0] <= IvA;
      chain_q[1] <= IvB;
      chain_q[2] <= IvC;
      chain_q[3] <= IvD;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      widx_q  <= widx_d;
      first_q <= first_d;
      len_q   <= len_d;
      fin_q   <= fin_d;
      pend_q  <= pend_d;
      ovf_q   <= ovf_d;
      oidx_q  <= oidx_d;
      cnt_q   <= cnt_d;
      for (int k = 0; k < 4; k++) begin
        chain_q[k] <= chain_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wacc_q <= wacc_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    d_q    <= d_d;
  end

  // Block store: sixteen little-endian message words.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("input ready while digest words are offered");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND) |-> (step_q <= LastStep))
    else $error("compression step out of range");

  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && m_axis_tlast_o) |=> (cnt_q == 64'd0) && s_axis_tready_o)
    else $error("state not restored after the last digest word");

  a_pad_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PAD && widx_q == LenWordHi) |=> (state_q == S_LOAD))
    else $error("padding did not hand over to compression");

  a_last_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && step_q == LastStep) |=> (state_q == S_FOLD))
    else $error("compression did not end after the last step");

endmodule
